[rtl/core/lfs_pkg.sv]
// Shared widths, codes and scoring functions for the line-follow steering block.
package lfs_pkg;

  localparam int unsigned DEF_HISTORY_DEPTH = 100;
  localparam int unsigned DEF_LAP_WINDOW    = 30;

  localparam int SENSOR_W = 5;
  localparam int SPEED_W  = 7;
  localparam int WHEEL_W  = 10;
  localparam int MODE_W   = 2;
  localparam int WEIGHT_W = 5;
  localparam int DIV_W    = 4;
  localparam int NUM_W    = 11;

  typedef logic signed [NUM_W:0]    num_t;
  typedef logic signed [WEIGHT_W-1:0] weight_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_CENTER     = 2'd0,
    MODE_LOST_LEFT  = 2'd1,
    MODE_LOST_RIGHT = 2'd2
  } mode_t;

  typedef enum logic {
    REG_LINE_IS_WHITE = 1'b0,
    REG_CRUISE_SPEED  = 1'b1
  } reg_idx_t;

  localparam logic            RST_LINE_IS_WHITE = 1'b1;
  localparam logic [SPEED_W-1:0] RST_CRUISE_SPEED = 7'd60;

  localparam num_t    KP_TIMES_TWO   = 12'sd38;
  localparam weight_t LOST_WEIGHT    = 5'sd9;
  localparam logic [DIV_W-1:0] LOST_INFLUENCE = 4'd2;

  localparam weight_t SIDE_WEIGHT [SENSOR_W] = '{5'sd3, 5'sd1, 5'sd0, -5'sd1, -5'sd3};

  function automatic weight_t frame_weight(input logic [SENSOR_W-1:0] f);
    weight_t acc;
    acc = '0;
    for (int b = 0; b < SENSOR_W; b++) begin
      if (f[b]) begin
        acc = acc + SIDE_WEIGHT[b];
      end
    end
    return acc;
  endfunction

  function automatic logic [DIV_W-1:0] frame_influence(input logic [SENSOR_W-1:0] f);
    logic [DIV_W-1:0] acc;
    acc = '0;
    for (int b = 0; b < SENSOR_W; b++) begin
      if (f[b]) begin
        acc = acc + ((b == 2) ? DIV_W'(1) : DIV_W'(2));
      end
    end
    return acc;
  endfunction

endpackage

[rtl/core/lfs_if.sv]
// Valid/ready channel interfaces for sensor frames and wheel commands.
interface lfs_in_if;
  import lfs_pkg::*;
  logic                valid;
  logic                ready;
  logic [SENSOR_W-1:0] raw_sensors;
  logic                careful;
  modport source (output valid, raw_sensors, careful, input ready);
  modport sink (input valid, raw_sensors, careful, output ready);
endinterface

interface lfs_out_if;
  import lfs_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [WHEEL_W-1:0] left_wheel;
  logic signed [WHEEL_W-1:0] right_wheel;
  logic [MODE_W-1:0]         track_mode;
  logic                      lap_mark_seen;
  modport source (output valid, left_wheel, right_wheel, track_mode, lap_mark_seen,
                  input ready);
  modport sink (input valid, left_wheel, right_wheel, track_mode, lap_mark_seen,
                output ready);
endinterface

[rtl/core/line_follow_steering.sv]
// Top level of the line-follow steering block: control, registers and result output.
//
// One frame beat on sense (raw_sensors, careful) yields one command beat on drive
// (left_wheel, right_wheel, track_mode, lap_mark_seen), in order.
// sense is ready only while the block is idle; a frame is taken, pushed into
// the outer-bit history in the next cycle, scored and mode-resolved in the one
// after, then the two wheel quotients come out of a pair of bit-serial dividers
// at one quotient bit per cycle.
// sense stays low through the history, scoring and divide steps, so a new frame
// is taken only once the previous command has moved into the drive register.
// The drive output register holds the finished command, so the next frame is
// taken while a command waits; if drive stays stalled when the next command is
// ready, the block holds it and keeps sense low until drive takes its beat.
// Configuration goes through the APB-style port: line_is_white at 0x0,
// cruise_speed at 0x4; line_is_white applies from the next frame taken, cruise_speed from the next frame scored.
// Synchronous reset clears history, recency sums, lap ages (to not seen),
// mode (centered) and loads line_is_white=1, cruise_speed=60; no clearing pass.
module line_follow_steering #(
  parameter int unsigned HISTORY_DEPTH = lfs_pkg::DEF_HISTORY_DEPTH,
  parameter int unsigned LAP_WINDOW    = lfs_pkg::DEF_LAP_WINDOW
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  lfs_in_if.sink      sense,
  lfs_out_if.source   drive
);
  import lfs_pkg::*;

  localparam int SUM_W = $clog2(HISTORY_DEPTH * (HISTORY_DEPTH + 1) / 2 + 1);
  localparam logic [SUM_W-1:0] LOST_LIMIT = SUM_W'(HISTORY_DEPTH * 4);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HIST = 5'b00010,
    S_MODE = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic                line_is_white;
  logic [SPEED_W-1:0]  cruise_speed;
  logic [SENSOR_W-1:0] frame;
  logic                careful;
  mode_t               track_state;
  mode_t               mode_next;
  logic                pend_lap;
  logic                out_valid;
  logic [SUM_W-1:0]    lsum;
  logic [SUM_W-1:0]    rsum;
  logic                lap_seen;
  logic                dark;
  weight_t             weight;
  logic [DIV_W-1:0]    influence;
  logic [DIV_W-1:0]    divisor;
  logic [SPEED_W-1:0]  base;
  logic [NUM_W-1:0]    prod;
  num_t                corr;
  num_t                num_l;
  num_t                num_r;
  logic                l_done;
  logic                r_done;
  num_t                l_quo;
  num_t                r_quo;
  logic                in_beat;
  logic                out_free;
  logic                cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (reg_idx_t'(paddr[2]) == REG_CRUISE_SPEED) ?
                     {25'b0, cruise_speed} : {31'b0, line_is_white};

  always_ff @(posedge clk) begin
    if (rst) begin
      line_is_white <= RST_LINE_IS_WHITE;
      cruise_speed  <= RST_CRUISE_SPEED;
    end else if (cfg_write) begin
      case (reg_idx_t'(paddr[2]))
        REG_LINE_IS_WHITE: line_is_white <= pwdata[0];
        REG_CRUISE_SPEED:  cruise_speed  <= pwdata[SPEED_W-1:0];
        default:           line_is_white <= line_is_white;
      endcase
    end
  end

  assign sense.ready = (state == S_IDLE);
  assign in_beat     = sense.valid && sense.ready;
  assign out_free    = !out_valid || drive.ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_beat) state_next = S_HIST;
      S_HIST:  state_next = S_MODE;
      S_MODE:  state_next = S_DIV;
      S_DIV:   if (l_done) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      frame   <= sense.raw_sensors ^ {SENSOR_W{line_is_white}};
      careful <= sense.careful;
    end
  end

  lfs_history #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .LAP_WINDOW    (LAP_WINDOW)
  ) u_history (
    .clk      (clk),
    .rst      (rst),
    .push     (state == S_HIST),
    .frame    (frame),
    .lsum     (lsum),
    .rsum     (rsum),
    .lap_seen (lap_seen)
  );

  always_comb begin
    dark      = (frame == '0);
    mode_next = track_state;
    if (!dark) begin
      mode_next = MODE_CENTER;
    end else if (track_state == MODE_CENTER && (lsum > LOST_LIMIT || rsum > LOST_LIMIT)) begin
      mode_next = (lsum > rsum) ? MODE_LOST_LEFT : MODE_LOST_RIGHT;
    end
    weight    = '0;
    influence = '0;
    if (!dark) begin
      weight    = frame_weight(frame);
      influence = frame_influence(frame);
    end else if (mode_next == MODE_LOST_LEFT) begin
      weight    = -LOST_WEIGHT;
      influence = LOST_INFLUENCE;
    end else if (mode_next == MODE_LOST_RIGHT) begin
      weight    = LOST_WEIGHT;
      influence = LOST_INFLUENCE;
    end
  end

  assign base    = careful ? {1'b0, cruise_speed[SPEED_W-1:1]} : cruise_speed;
  assign divisor = (influence == '0) ? DIV_W'(1) : influence;
  assign prod    = NUM_W'(base) * NUM_W'(divisor);
  assign corr    = KP_TIMES_TWO * num_t'(weight);
  assign num_l   = num_t'({1'b0, prod}) + corr;
  assign num_r   = num_t'({1'b0, prod}) - corr;

  lfs_divider u_div_left (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_MODE),
    .dividend (num_l),
    .divisor  (divisor),
    .done     (l_done),
    .quotient (l_quo)
  );

  lfs_divider u_div_right (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_MODE),
    .dividend (num_r),
    .divisor  (divisor),
    .done     (r_done),
    .quotient (r_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      track_state <= MODE_CENTER;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_MODE) begin
        track_state <= mode_next;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (drive.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MODE) begin
      pend_lap <= lap_seen;
    end
    if (state == S_DONE && out_free) begin
      drive.left_wheel    <= l_quo[WHEEL_W-1:0];
      drive.right_wheel   <= r_quo[WHEEL_W-1:0];
      drive.track_mode    <= track_state;
      drive.lap_mark_seen <= pend_lap;
    end
  end

  assign drive.valid = out_valid;

  a_div_in_phase: assert property (@(posedge clk) disable iff (rst)
    l_done |-> (state == S_DIV))
    else $error("divider finished outside the divide phase");

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    l_done == r_done)
    else $error("wheel dividers out of step");

  a_lit_centers: assert property (@(posedge clk) disable iff (rst)
    (state == S_MODE) && (frame != '0) |=> (track_state == MODE_CENTER))
    else $error("lit frame did not return to centered mode");

endmodule

[rtl/core/lfs_history.sv]
// Outer-bit history shift lines, recency sums and lap-mark ages.
module lfs_history #(
  parameter int unsigned HISTORY_DEPTH = lfs_pkg::DEF_HISTORY_DEPTH,
  parameter int unsigned LAP_WINDOW    = lfs_pkg::DEF_LAP_WINDOW,
  localparam int SUM_W = $clog2(HISTORY_DEPTH * (HISTORY_DEPTH + 1) / 2 + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [lfs_pkg::SENSOR_W-1:0]  frame,
  output logic [SUM_W-1:0]              lsum,
  output logic [SUM_W-1:0]              rsum,
  output logic                          lap_seen
);
  import lfs_pkg::*;

  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int AGE_W = $clog2(LAP_WINDOW + 1);
  localparam logic [SUM_W-1:0] NEW_WEIGHT = SUM_W'(HISTORY_DEPTH);
  localparam logic [AGE_W-1:0] AGE_MAX    = AGE_W'(LAP_WINDOW);

  logic [HISTORY_DEPTH-1:0] left_line;
  logic [HISTORY_DEPTH-1:0] right_line;
  logic [CNT_W-1:0]         left_hit_count;
  logic [CNT_W-1:0]         right_hit_count;
  logic [AGE_W-1:0]         age [3];
  logic [2:0]               marks;

  assign marks = {frame[0], frame[2], frame[4]};

  always_ff @(posedge clk) begin
    if (rst) begin
      left_line       <= '0;
      right_line      <= '0;
      left_hit_count  <= '0;
      right_hit_count <= '0;
      lsum            <= '0;
      rsum            <= '0;
      for (int k = 0; k < 3; k++) begin
        age[k] <= AGE_MAX;
      end
    end else if (push) begin
      left_line  <= {left_line[HISTORY_DEPTH-2:0], frame[4]};
      right_line <= {right_line[HISTORY_DEPTH-2:0], frame[0]};
      left_hit_count  <= left_hit_count - CNT_W'(left_line[HISTORY_DEPTH-1])
                         + CNT_W'(frame[4]);
      right_hit_count <= right_hit_count - CNT_W'(right_line[HISTORY_DEPTH-1])
                         + CNT_W'(frame[0]);
      lsum <= lsum - SUM_W'(left_hit_count) + (frame[4] ? NEW_WEIGHT : '0);
      rsum <= rsum - SUM_W'(right_hit_count) + (frame[0] ? NEW_WEIGHT : '0);
      for (int k = 0; k < 3; k++) begin
        if (marks[k]) begin
          age[k] <= '0;
        end else if (age[k] >= AGE_MAX) begin
          age[k] <= AGE_MAX;
        end else begin
          age[k] <= age[k] + AGE_W'(1);
        end
      end
    end
  end

  assign lap_seen = (age[0] < AGE_MAX) && (age[1] < AGE_MAX) && (age[2] < AGE_MAX);

endmodule

[rtl/core/lfs_divider.sv]
// Bit-serial restoring divider for one signed wheel command.
module lfs_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  lfs_pkg::num_t             dividend,
  input  logic [lfs_pkg::DIV_W-1:0] divisor,
  output logic                      done,
  output lfs_pkg::num_t             quotient
);
  import lfs_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic             neg;
  logic [DIV_W:0]   rem_shift;
  logic [DIV_W:0]   rem_diff;
  logic             fits;
  num_t             mag;

  assign rem_shift = {rem, quo[NUM_W-1]};
  assign rem_diff  = rem_shift - {1'b0, dvs};
  assign fits      = (rem_shift >= {1'b0, dvs});
  assign mag       = dividend[NUM_W] ? -dividend : dividend;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= mag[NUM_W-1:0];
      rem <= '0;
      dvs <= divisor;
      neg <= dividend[NUM_W];
    end else if (busy) begin
      quo <= {quo[NUM_W-2:0], fits};
      rem <= fits ? rem_diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
    end
  end

  assign quotient = neg ? -num_t'({1'b0, quo}) : num_t'({1'b0, quo});

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for line_follow_steering: frame beats in, wheel commands checked.
module tb;
  import lfs_pkg::*;

  localparam int HIST_LEN    = DEF_HISTORY_DEPTH;
  localparam int MARK_WINDOW = DEF_LAP_WINDOW;
  localparam int STEER_GAIN  = 38;
  localparam int LOST_TURN   = 9;
  localparam int CFG_ROW     = 6;
  localparam int NUM_ROWS    = 24;
  localparam int NUM_PHASES  = 6;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    logic signed [WHEEL_W-1:0] left_w;
    logic signed [WHEEL_W-1:0] right_w;
    mode_t                     mode;
    logic                      lap;
  } cmd_t;

  typedef struct packed {
    logic [SENSOR_W-1:0] raw;
    logic                car;
    logic                typed;
    cmd_t                want;
  } frame_row_t;

  // rows before CFG_ROW run at reset settings, the rest with line_is_white=0, cruise_speed=127
  localparam frame_row_t DIRECTED [NUM_ROWS] = '{
    '{5'h1F, 1'b0, 1'b1, '{10'sd60, 10'sd60, MODE_CENTER, 1'b0}},
    '{5'h1B, 1'b0, 1'b1, '{10'sd60, 10'sd60, MODE_CENTER, 1'b0}},
    '{5'h0F, 1'b0, 1'b1, '{10'sd3, 10'sd117, MODE_CENTER, 1'b0}},
    '{5'h1E, 1'b0, 1'b1, '{10'sd117, 10'sd3, MODE_CENTER, 1'b1}},
    '{5'h00, 1'b1, 1'b1, '{10'sd30, 10'sd30, MODE_CENTER, 1'b1}},
    '{5'h0F, 1'b1, 1'b1, '{-10'sd27, 10'sd87, MODE_CENTER, 1'b1}},
    '{5'h10, 1'b0, 1'b0, '0},
    '{5'h10, 1'b0, 1'b0, '0},
    '{5'h10, 1'b1, 1'b0, '0},
    '{5'h10, 1'b0, 1'b0, '0},
    '{5'h10, 1'b0, 1'b0, '0},
    '{5'h00, 1'b0, 1'b0, '0},
    '{5'h00, 1'b1, 1'b0, '0},
    '{5'h04, 1'b0, 1'b0, '0},
    '{5'h01, 1'b0, 1'b0, '0},
    '{5'h01, 1'b0, 1'b0, '0},
    '{5'h01, 1'b1, 1'b0, '0},
    '{5'h01, 1'b0, 1'b0, '0},
    '{5'h01, 1'b0, 1'b0, '0},
    '{5'h01, 1'b0, 1'b0, '0},
    '{5'h00, 1'b0, 1'b0, '0},
    '{5'h1F, 1'b1, 1'b0, '0},
    '{5'h0A, 1'b0, 1'b0, '0},
    '{5'h15, 1'b1, 1'b0, '0}
  };

  bit          clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lfs_in_if  sense_ch ();
  lfs_out_if drive_ch ();

  line_follow_steering dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sense   (sense_ch),
    .drive   (drive_ch)
  );

  logic [SENSOR_W-1:0] recent_frames [HIST_LEN];
  mode_t               steer_mode;
  int                  mark_age [3];
  logic                cfg_white;
  logic [SPEED_W-1:0]  cfg_base;

  cmd_t pending_cmds [$];
  int   errors;
  int   frames_sent;
  int   cmds_checked;
  int   mode_hits [3];
  int   lap_hits;
  int   settings_used;
  bit   idle_on;
  int   stall_left;

  always #5 clk = ~clk;

  function automatic int age_next(input int age, input logic lit);
    if (lit) begin
      return 0;
    end
    return (age >= MARK_WINDOW) ? MARK_WINDOW : age + 1;
  endfunction

  function automatic cmd_t steer_predict(input logic [SENSOR_W-1:0] raw, input logic car);
    logic [SENSOR_W-1:0] f;
    int wgt, infl, base, lsum, rsum, lw, rw;
    cmd_t c;
    f = cfg_white ? ~raw : raw;
    for (int i = HIST_LEN - 1; i > 0; i--) begin
      recent_frames[i] = recent_frames[i-1];
    end
    recent_frames[0] = f;
    wgt = 0;
    infl = 0;
    if (f != '0) begin
      steer_mode = MODE_CENTER;
      if (f[4]) begin wgt -= 3; infl += 2; end
      if (f[3]) begin wgt -= 1; infl += 2; end
      if (f[2]) begin infl += 1; end
      if (f[1]) begin wgt += 1; infl += 2; end
      if (f[0]) begin wgt += 3; infl += 2; end
    end else begin
      if (steer_mode == MODE_CENTER) begin
        lsum = 0;
        rsum = 0;
        for (int i = 0; i < HIST_LEN; i++) begin
          if (recent_frames[i][0]) rsum += HIST_LEN - i;
          if (recent_frames[i][4]) lsum += HIST_LEN - i;
        end
        if (lsum > HIST_LEN * 4 || rsum > HIST_LEN * 4) begin
          steer_mode = (lsum > rsum) ? MODE_LOST_LEFT : MODE_LOST_RIGHT;
        end
      end
      if (steer_mode == MODE_LOST_RIGHT) begin
        wgt = LOST_TURN;
        infl = 2;
      end else if (steer_mode == MODE_LOST_LEFT) begin
        wgt = -LOST_TURN;
        infl = 2;
      end
    end
    base = car ? (int'(cfg_base) >> 1) : int'(cfg_base);
    if (infl == 0) begin
      lw = base;
      rw = base;
    end else begin
      lw = (base * infl + STEER_GAIN * wgt) / infl;
      rw = (base * infl - STEER_GAIN * wgt) / infl;
    end
    mark_age[0] = age_next(mark_age[0], f[4]);
    mark_age[1] = age_next(mark_age[1], f[2]);
    mark_age[2] = age_next(mark_age[2], f[0]);
    c.left_w  = WHEEL_W'(lw);
    c.right_w = WHEEL_W'(rw);
    c.mode    = steer_mode;
    c.lap     = (mark_age[0] < MARK_WINDOW) && (mark_age[1] < MARK_WINDOW) &&
                (mark_age[2] < MARK_WINDOW);
    return c;
  endfunction

  function automatic void flag_mismatch(input string what, input cmd_t want, input cmd_t got);
    errors++;
    if (errors <= 10) begin
      $display("mismatch (%s): expected L=%0d R=%0d mode=%0d lap=%0b, got L=%0d R=%0d mode=%0d lap=%0b",
               what, want.left_w, want.right_w, want.mode, want.lap,
               got.left_w, got.right_w, got.mode, got.lap);
    end
  endfunction

  task automatic write_reg(input reg_idx_t r, input logic [31:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(int'(r) * 4);
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (r)
      REG_LINE_IS_WHITE: cfg_white = v[0];
      REG_CRUISE_SPEED:  cfg_base  = v[SPEED_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic push_frame(input logic [SENSOR_W-1:0] raw, input logic car,
                            input logic typed, input cmd_t want);
    int gap;
    cmd_t c;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      @(negedge clk);
      sense_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    sense_ch.valid       <= 1'b1;
    sense_ch.raw_sensors <= raw;
    sense_ch.careful     <= car;
    @(posedge clk);
    while (!sense_ch.ready) @(posedge clk);
    c = steer_predict(raw, car);
    pending_cmds.push_back(typed ? want : c);
    frames_sent++;
  endtask

  // drop valid and hold until every command has come back
  task automatic settle();
    @(negedge clk);
    sense_ch.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    int sent, kind, len;
    logic [SENSOR_W-1:0] f;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        len = $urandom_range(1, 8);
      end else if (kind <= 6) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 35) : $urandom_range(1, 6);
      end else if (kind == 7) begin
        len = $urandom_range(1, 4);
      end else begin
        len = 1;
      end
      repeat (len) begin
        case (kind)
          0, 1:    f = 5'h10 | (5'($urandom) & 5'h08);
          2, 3:    f = 5'h01 | (5'($urandom) & 5'h02);
          4, 5, 6: f = 5'h00;
          7:       f = 5'h04 | (5'($urandom) & 5'h0A);
          default: f = 5'($urandom);
        endcase
        push_frame(f ^ {SENSOR_W{cfg_white}}, 1'($urandom_range(0, 1)), 1'b0, '0);
        sent++;
      end
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      drive_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      drive_ch.ready <= 1'b0;
    end else begin
      drive_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cmd_t got, want;
    if (!rst && drive_ch.valid && drive_ch.ready) begin
      got.left_w  = drive_ch.left_wheel;
      got.right_w = drive_ch.right_wheel;
      got.mode    = mode_t'(drive_ch.track_mode);
      got.lap     = drive_ch.lap_mark_seen;
      if (got.mode <= MODE_LOST_RIGHT) mode_hits[got.mode]++;
      if (got.lap) lap_hits++;
      if (pending_cmds.size() == 0) begin
        flag_mismatch("no command pending", '0, got);
      end else begin
        want = pending_cmds.pop_front();
        cmds_checked++;
        if (got.left_w !== want.left_w || got.right_w !== want.right_w ||
            got.mode !== want.mode || got.lap !== want.lap) begin
          flag_mismatch("command", want, got);
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("timeout: %0d frames sent, %0d commands pending", frames_sent, pending_cmds.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int w, b;
    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    sense_ch.valid       = 1'b0;
    sense_ch.raw_sensors = '0;
    sense_ch.careful     = 1'b0;
    drive_ch.ready       = 1'b0;
    idle_on              = 1'b1;
    stall_left           = 0;
    errors               = 0;
    frames_sent          = 0;
    cmds_checked         = 0;
    lap_hits             = 0;
    settings_used        = 1;
    mode_hits            = '{0, 0, 0};
    for (int i = 0; i < HIST_LEN; i++) recent_frames[i] = '0;
    steer_mode = MODE_CENTER;
    mark_age   = '{MARK_WINDOW, MARK_WINDOW, MARK_WINDOW};
    cfg_white  = RST_LINE_IS_WHITE;
    cfg_base   = RST_CRUISE_SPEED;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (i == CFG_ROW) begin
        settle();
        write_reg(REG_LINE_IS_WHITE, 32'd0);
        write_reg(REG_CRUISE_SPEED, 32'd127);
        settings_used++;
      end
      push_frame(DIRECTED[i].raw, DIRECTED[i].car, DIRECTED[i].typed, DIRECTED[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      if (p == NUM_PHASES - 1) idle_on = 1'b0;
      w = (p < 4) ? int'(p % 2 == 0) : $urandom_range(0, 1);
      b = (p == 0) ? 0 : (p == 1) ? 100 : (p == 2) ? 127 : $urandom_range(0, 127);
      write_reg(REG_LINE_IS_WHITE, 32'(w));
      write_reg(REG_CRUISE_SPEED, 32'(b));
      settings_used++;
      run_random(PHASE_ITEMS);
    end

    settle();
    repeat (20) @(posedge clk);
    errors += pending_cmds.size();

    $display("%0d frames, %0d commands checked over %0d register settings",
             frames_sent, cmds_checked, settings_used);
    $display("modes seen: centered %0d, lost-left %0d, lost-right %0d; lap marks %0d; errors %0d",
             mode_hits[0], mode_hits[1], mode_hits[2], lap_hits, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
